@@ src/smp_pkg.sv @@
// ----------------------------------------------------------------------------
// smp_pkg
// Shared constants and types of the stable multiway partition unit.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int unsigned NUM_PIVOTS  = 16;
  localparam int unsigned CAPACITY    = 4096;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned NUM_BUCKETS = NUM_PIVOTS + 1;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned BKT_W = $clog2(NUM_BUCKETS);

  typedef enum logic [1:0] {
    MODE_PIVOT = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREFIX,
    ST_SCATTER,
    ST_READ,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic latch;
    logic pivot_wr;
    logic data_wr;
    logic pfx_init;
    logic pfx_step;
    logic scat_step;
    logic set_draining;
    logic rd_issue;
    logic out_strobe;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  draining;
    logic  pfx_last;
    logic  scat_done;
  } stat_t;

endpackage

@@ src/stable_multiway_partition_unit.sv @@
// ----------------------------------------------------------------------------
// stable_multiway_partition_unit
// Samplesort distribution step: bucket elements against a pivot table and
// return them in stable bucket order.
// ----------------------------------------------------------------------------
// Usage: raise start with mode/pivot_slot/value while busy is low; the item is
// taken on that edge. Pivot and data loads give no result. A read answers
// with a one-cycle result_valid_o pulse; the receiver cannot stall, so it must
// take the result in that cycle. The first read after a data set is loaded
// also runs the prefix pass over the 17 bucket counters (one per cycle) and
// the scatter pass (one element per cycle through the element store's read
// port, registered before it is written to the output store). Loads beyond
// 4096 elements are dropped and reported on overflow_o. A data load after
// reads begins a new set.
// ----------------------------------------------------------------------------
module stable_multiway_partition_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  pivot_slot_i,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic [31:0] value_res_o,
  output logic [4:0]  bucket_o,
  output logic [12:0] bucket_size_o,
  output logic        last_o,
  output logic        empty_res_o,
  output logic        overflow_o
);

  smp_pkg::cmd_t  cmd;   // controller -> datapath
  smp_pkg::stat_t stat;  // datapath -> controller

  smp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  smp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .pivot_slot_i   (pivot_slot_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .value_res_o    (value_res_o),
    .bucket_o       (bucket_o),
    .bucket_size_o  (bucket_size_o),
    .last_o         (last_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

@@ src/smp_ctrl.sv @@
// ----------------------------------------------------------------------------
// smp_ctrl
// Sequencer: command decode, prefix pass, scatter pass and read timing.
// ----------------------------------------------------------------------------
module smp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  smp_pkg::stat_t stat_i,
  output smp_pkg::cmd_t  cmd_o
);

  smp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smp_pkg::ST_IDLE: begin
        if (start) state_d = smp_pkg::ST_EXEC;
      end
      smp_pkg::ST_EXEC: begin
        if (stat_i.mode == smp_pkg::MODE_READ) begin
          state_d = stat_i.draining ? smp_pkg::ST_READ : smp_pkg::ST_PREFIX;
        end else begin
          state_d = smp_pkg::ST_IDLE;
        end
      end
      smp_pkg::ST_PREFIX: begin
        if (stat_i.pfx_last) state_d = smp_pkg::ST_SCATTER;
      end
      smp_pkg::ST_SCATTER: begin
        if (stat_i.scat_done) state_d = smp_pkg::ST_READ;
      end
      smp_pkg::ST_READ:   state_d = smp_pkg::ST_RESULT;
      smp_pkg::ST_RESULT: state_d = smp_pkg::ST_IDLE;
      default:            state_d = smp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = (state_q != smp_pkg::ST_IDLE);
    unique case (state_q)
      smp_pkg::ST_IDLE:    cmd_o.latch = start;
      smp_pkg::ST_EXEC: begin
        cmd_o.pivot_wr = (stat_i.mode == smp_pkg::MODE_PIVOT);
        cmd_o.data_wr  = (stat_i.mode == smp_pkg::MODE_DATA);
        cmd_o.pfx_init = (stat_i.mode == smp_pkg::MODE_READ) && !stat_i.draining;
      end
      smp_pkg::ST_PREFIX:  cmd_o.pfx_step = 1'b1;
      smp_pkg::ST_SCATTER: begin
        cmd_o.scat_step    = 1'b1;
        cmd_o.set_draining = stat_i.scat_done;
      end
      smp_pkg::ST_READ:    cmd_o.rd_issue = 1'b1;
      smp_pkg::ST_RESULT:  cmd_o.out_strobe = 1'b1;
      default:             cmd_o = '0;
    endcase
  end

endmodule

@@ src/smp_datapath.sv @@
// ----------------------------------------------------------------------------
// smp_datapath
// Pivot table, classifier, bucket counters, element and output stores.
// ----------------------------------------------------------------------------
module smp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  mode_i,
  input  logic [3:0]                  pivot_slot_i,
  input  logic [31:0]                 value_i,
  input  smp_pkg::cmd_t               cmd_i,
  output smp_pkg::stat_t              stat_o,
  output logic                        result_valid_o,
  output logic [31:0]                 value_res_o,
  output logic [4:0]                  bucket_o,
  output logic [12:0]                 bucket_size_o,
  output logic                        last_o,
  output logic                        empty_res_o,
  output logic                        overflow_o
);

  localparam int unsigned DW    = smp_pkg::DATA_WIDTH;
  localparam int unsigned BW    = smp_pkg::BKT_W;
  localparam int unsigned CW    = smp_pkg::CNT_W;
  localparam int unsigned AW    = smp_pkg::AW;
  localparam int unsigned NB    = smp_pkg::NUM_BUCKETS;
  localparam int unsigned NP    = smp_pkg::NUM_PIVOTS;
  localparam int unsigned EW    = DW + BW;
  localparam int unsigned OW    = DW + BW + CW;

  // latched command
  smp_pkg::mode_e mode_q;
  logic [3:0]     slot_q;
  logic [DW-1:0]  val_q;

  logic [DW-1:0] pivot_q [NP];
  logic [CW-1:0] count_q [NB];
  logic [CW-1:0] next_q  [NB];
  logic [CW-1:0] elem_cnt_q, rp_q, scat_i_q, sum_q;
  logic [BW-1:0] pfx_k_q;
  logic          draining_q, dropped_q, pend_q;
  logic          empty_q, last_q;

  logic [EW-1:0] elem_mem [smp_pkg::CAPACITY];
  logic [OW-1:0] out_mem  [smp_pkg::CAPACITY];
  logic [EW-1:0] elem_rd_q;
  logic [OW-1:0] out_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= smp_pkg::mode_e'(mode_i);
      slot_q <= pivot_slot_i;
      val_q  <= value_i[DW-1:0];
    end
  end

  // classifier: first matching pivot wins
  logic [BW-1:0] tag;
  always_comb begin
    tag = BW'(NP);
    for (int k = NP - 1; k >= 0; k--) begin
      if (k == 0) begin
        if (val_q < pivot_q[k]) tag = BW'(k);
      end else if (val_q <= pivot_q[k]) begin
        tag = BW'(k);
      end
    end
  end

  logic          clr, accept_elem, scat_issue;
  logic [CW-1:0] cnt_eff;
  logic [BW-1:0] sb;
  assign clr         = cmd_i.data_wr && draining_q;
  assign cnt_eff     = clr ? '0 : elem_cnt_q;
  assign accept_elem = cmd_i.data_wr && (cnt_eff < CW'(smp_pkg::CAPACITY));
  assign scat_issue  = cmd_i.scat_step && (scat_i_q < elem_cnt_q);
  assign sb          = elem_rd_q[DW +: BW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NP; k++) pivot_q[k] <= '0;
      for (int k = 0; k < NB; k++) count_q[k] <= '0;
      elem_cnt_q <= '0;
      rp_q       <= '0;
      draining_q <= 1'b0;
      dropped_q  <= 1'b0;
      pend_q     <= 1'b0;
      pfx_k_q    <= '0;
      sum_q      <= '0;
      scat_i_q   <= '0;
    end else begin
      if (cmd_i.pivot_wr && ({1'b0, slot_q} < 5'(NP))) begin
        pivot_q[slot_q[$clog2(NP > 1 ? NP : 2)-1:0]] <= val_q;
      end
      if (cmd_i.data_wr) begin
        for (int k = 0; k < NB; k++) begin
          count_q[k] <= (clr ? '0 : count_q[k]) +
                        CW'(accept_elem && (tag == BW'(k)));
        end
        elem_cnt_q <= cnt_eff + CW'(accept_elem);
        if (clr) begin
          rp_q       <= '0;
          draining_q <= 1'b0;
        end
        dropped_q <= (clr ? 1'b0 : dropped_q) | !accept_elem;
      end
      if (cmd_i.pfx_init) begin
        pfx_k_q  <= '0;
        sum_q    <= '0;
        scat_i_q <= '0;
        pend_q   <= 1'b0;
      end
      if (cmd_i.pfx_step) begin
        sum_q   <= sum_q + count_q[pfx_k_q];
        pfx_k_q <= pfx_k_q + 1'b1;
      end
      if (cmd_i.scat_step) begin
        pend_q <= scat_issue;
        if (scat_issue) scat_i_q <= scat_i_q + 1'b1;
      end
      if (cmd_i.set_draining) draining_q <= 1'b1;
      if (cmd_i.rd_issue && (rp_q < elem_cnt_q)) rp_q <= rp_q + 1'b1;
    end
  end

  // prefix targets, advanced as the scatter writes each element into its bucket
  always_ff @(posedge clk_i) begin
    if (cmd_i.pfx_step) next_q[pfx_k_q] <= sum_q;
    if (cmd_i.scat_step && pend_q) next_q[sb] <= next_q[sb] + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (accept_elem) elem_mem[cnt_eff[AW-1:0]] <= {tag, val_q};
    if (scat_issue)  elem_rd_q <= elem_mem[scat_i_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scat_step && pend_q) begin
      out_mem[next_q[sb][AW-1:0]] <= {count_q[sb], sb, elem_rd_q[DW-1:0]};
    end
    if (cmd_i.rd_issue) begin
      out_rd_q <= out_mem[rp_q[AW-1:0]];
      empty_q  <= !(rp_q < elem_cnt_q);
      last_q   <= (rp_q + 1'b1 == elem_cnt_q);
    end
  end

  assign stat_o.mode      = mode_q;
  assign stat_o.draining  = draining_q;
  assign stat_o.pfx_last  = (pfx_k_q == BW'(NB - 1));
  assign stat_o.scat_done = !(scat_i_q < elem_cnt_q) && !pend_q;

  assign result_valid_o = cmd_i.out_strobe;
  assign value_res_o    = empty_q ? '0 : 32'(out_rd_q[DW-1:0]);
  assign bucket_o       = empty_q ? '0 : 5'(out_rd_q[DW +: BW]);
  assign bucket_size_o  = empty_q ? '0 : 13'(out_rd_q[DW + BW +: CW]);
  assign last_o         = !empty_q && last_q;
  assign empty_res_o    = empty_q;
  assign overflow_o     = dropped_q;

endmodule
